// ===== rtl/ovc_pkg.sv =====
// ----------------------------------------------------------------------------
// ovc_pkg
// Shared types, codes and arithmetic helpers for the occupancy value colorizer.
// ----------------------------------------------------------------------------
package ovc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 9;
   localparam int unsigned CHAN_WIDTH      = 8;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_PALETTE_KIND    = 2'd0;
   localparam csr_index_type CSR_BINARY_MODE     = 2'd1;
   localparam csr_index_type CSR_SPLIT_THRESHOLD = 2'd2;

   typedef logic [1:0] palette_kind_type;

   localparam palette_kind_type PAL_MAP     = 2'd0;
   localparam palette_kind_type PAL_COSTMAP = 2'd1;
   localparam palette_kind_type PAL_RAW     = 2'd2;

   localparam logic [8:0] THRESHOLD_MAX   = 9'd256;
   localparam logic [8:0] THRESHOLD_RESET = 9'd100;

   localparam logic [7:0] OCC_LIMIT      = 8'd100;
   localparam logic [7:0] COST_RAMP_TOP  = 8'd98;
   localparam logic [7:0] COST_CYAN      = 8'd99;
   localparam logic [7:0] GREEN_TOP      = 8'd127;
   localparam logic [7:0] UPPER_RAMP_LOW = 8'd128;
   localparam logic [7:0] UPPER_RAMP_TOP = 8'd254;

   localparam logic [7:0] UNKNOWN_RED   = 8'h70;
   localparam logic [7:0] UNKNOWN_GREEN = 8'h89;
   localparam logic [7:0] UNKNOWN_BLUE  = 8'h86;

   typedef struct packed {
      palette_kind_type palette_kind;
      logic             binary_mode;
      logic [8:0]       split_threshold;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] red;
      logic [CHAN_WIDTH-1:0] green;
      logic [CHAN_WIDTH-1:0] blue;
      logic [CHAN_WIDTH-1:0] opacity;
   } rgba_type;

   // floor(255 * v / 100) for v in 0..100, reciprocal 5243 / 2^19
   function automatic logic [7:0] scale_100(input logic [7:0] v);
      logic [15:0] x;
      logic [31:0] p;
      x = {v, 8'd0} - {8'd0, v};
      p = {16'd0, x} * 32'd5243;
      return p[26:19];
   endfunction

   // floor(255 * d / 126) for d in 0..126, reciprocal 33289 / 2^22
   function automatic logic [7:0] scale_126(input logic [6:0] d);
      logic [14:0] x;
      logic [31:0] p;
      x = {d, 8'd0} - {8'd0, d};
      p = {17'd0, x} * 32'd33289;
      return p[29:22];
   endfunction

endpackage

// ===== rtl/ovc_csr.sv =====
// ----------------------------------------------------------------------------
// ovc_csr
// Configuration registers: palette kind, binary mode and saturating threshold.
// ----------------------------------------------------------------------------
module ovc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  ovc_pkg::csr_index_type              csr_index,
   input  logic [ovc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output ovc_pkg::cfg_type                    cfg
);

   ovc_pkg::cfg_type cfg_ff;
   ovc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            ovc_pkg::CSR_PALETTE_KIND: cfg_in.palette_kind = csr_wdata[1:0];
            ovc_pkg::CSR_BINARY_MODE:  cfg_in.binary_mode  = csr_wdata[0];
            ovc_pkg::CSR_SPLIT_THRESHOLD: begin
               cfg_in.split_threshold = (csr_wdata > ovc_pkg::THRESHOLD_MAX) ?
                                        ovc_pkg::THRESHOLD_MAX : csr_wdata;
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.palette_kind    <= ovc_pkg::PAL_MAP;
         cfg_ff.binary_mode     <= 1'b0;
         cfg_ff.split_threshold <= ovc_pkg::THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/ovc_color.sv =====
// ----------------------------------------------------------------------------
// ovc_color
// Palette lookup: computes the RGBA color of one cell value.
// ----------------------------------------------------------------------------
module ovc_color (
   input  ovc_pkg::cfg_type  cfg,
   input  logic [7:0]        cell_value,
   output ovc_pkg::rgba_type color
);

   logic       below;
   logic [7:0] lower_ramp;
   logic [7:0] upper_ramp;
   logic [6:0] upper_offset;
   logic [7:0] upper_diff;

   ovc_pkg::rgba_type upper_color;

   assign below        = {1'b0, cell_value} < cfg.split_threshold;
   assign lower_ramp   = ovc_pkg::scale_100(cell_value);
   assign upper_diff   = cell_value - ovc_pkg::UPPER_RAMP_LOW;
   assign upper_offset = upper_diff[6:0];
   assign upper_ramp   = ovc_pkg::scale_126(upper_offset);

   always_comb begin
      if (cell_value <= ovc_pkg::GREEN_TOP) begin
         upper_color = '{8'd0, 8'd255, 8'd0, 8'd255};
      end else if (cell_value <= ovc_pkg::UPPER_RAMP_TOP) begin
         upper_color = '{8'd255, upper_ramp, 8'd0, 8'd255};
      end else begin
         upper_color = '{ovc_pkg::UNKNOWN_RED, ovc_pkg::UNKNOWN_GREEN,
                         ovc_pkg::UNKNOWN_BLUE, 8'd255};
      end
   end

   always_comb begin
      case (cfg.palette_kind)
         ovc_pkg::PAL_MAP: begin
            if (cell_value > ovc_pkg::OCC_LIMIT) begin
               color = upper_color;
            end else if (cfg.binary_mode) begin
               color = below ? '{8'd255, 8'd255, 8'd255, 8'd255} :
                               '{8'd0, 8'd0, 8'd0, 8'd255};
            end else begin
               color = '{~lower_ramp, ~lower_ramp, ~lower_ramp, 8'd255};
            end
         end
         ovc_pkg::PAL_COSTMAP: begin
            if (cell_value > ovc_pkg::OCC_LIMIT) begin
               color = upper_color;
            end else if (cfg.binary_mode) begin
               color = below ? '{8'd0, 8'd0, 8'd255, 8'd255} :
                               '{8'd255, 8'd0, 8'd0, 8'd255};
            end else if (cell_value == 8'd0) begin
               color = '{8'd0, 8'd0, 8'd0, 8'd0};
            end else if (cell_value <= ovc_pkg::COST_RAMP_TOP) begin
               color = '{lower_ramp, 8'd0, ~lower_ramp, 8'd255};
            end else if (cell_value == ovc_pkg::COST_CYAN) begin
               color = '{8'd0, 8'd255, 8'd255, 8'd255};
            end else begin
               color = '{8'd255, 8'd0, 8'd255, 8'd255};
            end
         end
         default: begin
            if (cfg.binary_mode) begin
               color = below ? '{8'd0, 8'd0, 8'd0, 8'd255} :
                               '{8'd255, 8'd255, 8'd255, 8'd255};
            end else begin
               color = '{cell_value, cell_value, cell_value, 8'd255};
            end
         end
      endcase
   end

endmodule

// ===== rtl/occupancy_value_colorizer_top.sv =====
// ----------------------------------------------------------------------------
// occupancy_value_colorizer_top
// Occupancy-grid cell byte to RGBA color, one word per cycle while the result side keeps up.
// ----------------------------------------------------------------------------
// Each cell word passes an input register, the palette logic and a result
// register. A color reaches the result ports when its cell moves on from the
// input register, which waits while the result side stalls. A new cell is taken
// every cycle while the result side keeps up. The two parallel constant-reciprocal
// multiplies in the palette logic set the cycle time.
// Write the configuration registers only while no cell is in flight.
module occupancy_value_colorizer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_cell_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_red,
   output logic [7:0]                          rsp_green,
   output logic [7:0]                          rsp_blue,
   output logic [7:0]                          rsp_opacity,
   input  logic                                csr_write,
   input  ovc_pkg::csr_index_type              csr_index,
   input  logic [ovc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   ovc_pkg::cfg_type  cfg;
   ovc_pkg::rgba_type color;
   ovc_pkg::rgba_type rsp_color_ff;

   logic       cell_valid_ff;
   logic [7:0] cell_value_ff;
   logic       rsp_valid_ff;
   logic       rsp_load;
   logic       req_take;

   ovc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ovc_color u_color (
      .cfg        (cfg),
      .cell_value (cell_value_ff),
      .color      (color)
   );

   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = cell_valid_ff && !rsp_load;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (!req_stall) begin
            cell_valid_ff <= req_valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= cell_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cell_value_ff <= req_cell_value;
      end
      if (rsp_load && cell_valid_ff) begin
         rsp_color_ff <= color;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_red     = rsp_color_ff.red;
   assign rsp_green   = rsp_color_ff.green;
   assign rsp_blue    = rsp_color_ff.blue;
   assign rsp_opacity = rsp_color_ff.opacity;

   a_threshold_saturated: assert property (@(posedge clock) disable iff (reset)
      cfg.split_threshold <= ovc_pkg::THRESHOLD_MAX)
      else $error("split threshold above saturation limit");

   a_cell_advances: assert property (@(posedge clock) disable iff (reset)
      cell_valid_ff && rsp_load |=> rsp_valid_ff)
      else $error("accepted cell word lost before result register");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> cell_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled while pipeline has room");

   a_transparent_costmap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_color_ff.opacity == 8'd0 |->
         cfg.palette_kind == ovc_pkg::PAL_COSTMAP && !cfg.binary_mode)
      else $error("transparent color outside costmap ramp");

endmodule
